// ===== rtl/itp_pkg.sv =====
// Shared types, constants and helper functions for the integer text parser.
// Used by itp_ctrl, itp_datapath and integer_text_parser; depends on nothing.
`default_nettype none

package itp_pkg;

  // Arithmetic width of the accumulator, and the text length the position counter covers.
  localparam int unsigned VALUE_WIDTH     = 64;
  localparam int unsigned MAX_TEXT_LENGTH = 4095;
  localparam int unsigned POS_W           = $clog2(MAX_TEXT_LENGTH + 1);

  // Port widths fixed by the field definitions.
  localparam int unsigned OUT_W      = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned MUL_W      = VALUE_WIDTH + BASE_W;
  localparam int unsigned SUM_W      = MUL_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE  = 2'd3;

  // Radix codes.
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] DIGIT_NONE = 6'h3F;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  // Saturation limits.
  localparam logic [VALUE_WIDTH-1:0] LIM_UNSIGNED = {VALUE_WIDTH{1'b1}};
  localparam logic [VALUE_WIDTH-1:0] LIM_POS      = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] LIM_NEG      = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_LEAD   = 5'b00010,
    PH_SIGNED = 5'b00100,
    PH_ZERO   = 5'b01000,
    PH_DIGITS = 5'b10000
  } parse_phase_e;

  typedef enum logic [2:0] {
    CS_READY = 3'b001,
    CS_EXEC  = 3'b010,
    CS_HOLD  = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic load;    // capture the accepted beat and start the multiply
    logic commit;  // apply the evaluated step to the parse state
  } dp_cmd_t;

  typedef struct packed {
    logic result_req;  // the evaluated step ends the parse with a result
  } dp_sts_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [BASE_W-1:0] digit_of(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      v = c - CH_ZERO;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      v = c - CH_UP_A + 8'd10;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      v = c - CH_LO_A + 8'd10;
    end else begin
      v = {2'b00, DIGIT_NONE};
    end
    return v[BASE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_text_parser.sv =====
// Top level of the integer text parser: joins the controller and datapath.
// Depends on itp_pkg, itp_ctrl and itp_datapath.
`default_nettype none

//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+---------------------
//  input    | start_of_text_i, char_code_i              | in_valid_i/in_ready_o
//  output   | parsed_value_o, parse_status_o, end_offset_o | out_valid_o/out_ready_i
//  config   | cfg_we_i, cfg_index_i, cfg_data_i         | write enable only
//
//  Each beat runs in two steps. Acceptance registers the character, its digit
//  value and the accumulator times the radix; the evaluate state adds the digit,
//  checks the range and commits the step, but a beat that yields a result while
//  the output register is still full waits there until that register is freed.
//  Reset restores base 10 and signed mode and leaves the parser idle.

module integer_text_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [itp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [itp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            start_of_text_i,
  input  wire logic [7:0]                      char_code_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [itp_pkg::OUT_W-1:0]            parsed_value_o,
  output logic [itp_pkg::STATUS_W-1:0]         parse_status_o,
  output logic [itp_pkg::OFFSET_W-1:0]         end_offset_o
);
  import itp_pkg::*;

  // Commands go from the controller to the datapath, status comes back.
  dp_cmd_t cmd;
  dp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  itp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start_of_text_i (start_of_text_i),
    .char_code_i     (char_code_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .parsed_value_o  (parsed_value_o),
    .parse_status_o  (parse_status_o),
    .end_offset_o    (end_offset_o)
  );

  // An accepted beat always occupies the next cycle.
  a_two_cycle_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // A new result is committed only as the controller returns to accepting.
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result committed without freeing the input");

  // Results without digits carry neither value nor offset.
  a_no_digit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((parse_status_o == ST_NO_DIGITS) || (parse_status_o == ST_BAD_BASE)))
      |-> ((end_offset_o == '0) && (parsed_value_o == '0)))
    else $error("empty parse reported a value or offset");

endmodule

`default_nettype wire

// ===== rtl/itp_ctrl.sv =====
// Sequencing controller of the integer text parser: input acceptance,
// step commit and the output valid flag. Depends on itp_pkg.
`default_nettype none

module itp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            out_ready_i,
  input  wire itp_pkg::dp_sts_t sts_i,
  output itp_pkg::dp_cmd_t     cmd_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);
  import itp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        evaluating;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign evaluating = (state_q == CS_EXEC) || (state_q == CS_HOLD);

  assign in_ready_o    = (state_q == CS_READY);
  assign cmd_o.load    = in_ready_o && in_valid_i;
  assign cmd_o.commit  = evaluating && (!sts_i.result_req || slot_free);
  assign out_valid_o   = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      CS_READY: begin
        if (in_valid_i) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC, CS_HOLD: begin
        // A result waits here until the output register can take it.
        state_d = cmd_o.commit ? CS_READY : CS_HOLD;
      end
      default: begin
        state_d = CS_READY;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit && sts_i.result_req) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_READY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itp_datapath.sv =====
// Datapath of the integer text parser: configuration registers, parse state,
// radix multiply, range check and the result register. Depends on itp_pkg.
`default_nettype none

module itp_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [itp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [itp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          start_of_text_i,
  input  wire logic [7:0]                    char_code_i,
  input  wire itp_pkg::dp_cmd_t              cmd_i,
  output itp_pkg::dp_sts_t                   sts_o,
  output logic [itp_pkg::OUT_W-1:0]          parsed_value_o,
  output logic [itp_pkg::STATUS_W-1:0]       parse_status_o,
  output logic [itp_pkg::OFFSET_W-1:0]       end_offset_o
);
  import itp_pkg::*;

  // Configuration.
  logic [BASE_W-1:0] number_base_q;
  logic              signed_mode_q;

  // Parse state.
  parse_phase_e           phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [BASE_W-1:0]      abase_q, abase_d;
  logic                   seen_q, seen_d;
  logic                   ovf_q, ovf_d;
  logic                   held_q, held_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic                   msigned_q, msigned_d;

  // Captured beat and first-cycle products.
  logic                   sot_q;
  logic [7:0]             char_q;
  logic [BASE_W-1:0]      digit_q;
  logic [MUL_W-1:0]       mul_q;

  // Result register.
  logic [OUT_W-1:0]       value_q, value_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [OFFSET_W-1:0]    offset_q, offset_d;
  logic                   res_req;

  logic [BASE_W-1:0]      base_sel;
  logic [BASE_W-1:0]      base_mul;
  logic [VALUE_WIDTH-1:0] acc_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_DEC;
      signed_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NUMBER_BASE: number_base_q <= cfg_data_i[BASE_W-1:0];
        REG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The multiply uses the radix this beat's digit step will see.
  always_comb begin
    base_sel = start_of_text_i ? number_base_q : abase_q;
    base_mul = base_sel;
    if (base_sel == BASE_AUTO) begin
      base_mul = (!start_of_text_i && (phase_q == PH_ZERO)) ? BASE_OCT : BASE_DEC;
    end
    acc_in = start_of_text_i ? '0 : acc_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sot_q   <= start_of_text_i;
      char_q  <= char_code_i;
      digit_q <= digit_of(char_code_i);
      mul_q   <= MUL_W'(acc_in) * MUL_W'(base_mul);
    end
  end

  always_comb begin
    logic                   first;
    logic                   feed;
    logic                   counting;
    logic [VALUE_WIDTH-1:0] limit;
    logic [SUM_W-1:0]       sum;
    logic [VALUE_WIDTH-1:0] mag;

    phase_d   = phase_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    abase_d   = abase_q;
    seen_d    = seen_q;
    ovf_d     = ovf_q;
    held_d    = held_q;
    pos_d     = pos_q;
    msigned_d = msigned_q;
    value_d   = '0;
    status_d  = ST_OK;
    offset_d  = '0;
    res_req   = 1'b0;
    first     = 1'b0;
    feed      = 1'b0;
    counting  = 1'b1;
    limit     = LIM_UNSIGNED;
    sum       = SUM_W'(mul_q) + SUM_W'(digit_q);
    mag       = '0;

    if (sot_q) begin
      phase_d   = PH_LEAD;
      acc_d     = '0;
      neg_d     = 1'b0;
      seen_d    = 1'b0;
      ovf_d     = 1'b0;
      held_d    = 1'b0;
      pos_d     = '0;
      msigned_d = signed_mode_q;
      abase_d   = number_base_q;
      if ((number_base_q == 6'd1) || (number_base_q > BASE_MAX)) begin
        res_req  = 1'b1;
        status_d = ST_BAD_BASE;
        phase_d  = PH_IDLE;
        counting = 1'b0;
      end
    end

    if (!res_req) begin
      unique case (phase_d)
        PH_IDLE: begin
          counting = 1'b0;
        end
        PH_LEAD: begin
          if (is_blank(char_q)) begin
            phase_d = PH_LEAD;
          end else if ((char_q == CH_PLUS) || (char_q == CH_MINUS)) begin
            neg_d   = (char_q == CH_MINUS);
            phase_d = PH_SIGNED;
          end else begin
            first = 1'b1;
          end
        end
        PH_SIGNED: begin
          first = 1'b1;
        end
        PH_ZERO: begin
          held_d = 1'b0;
          if ((char_q == CH_LO_X) || (char_q == CH_UP_X)) begin
            abase_d = BASE_HEX;
            phase_d = PH_DIGITS;
          end else begin
            if (abase_d == BASE_AUTO) begin
              abase_d = BASE_OCT;
            end
            acc_d  = '0;
            seen_d = 1'b1;
            feed   = 1'b1;
          end
        end
        PH_DIGITS: begin
          feed = 1'b1;
        end
        default: begin
          counting = 1'b0;
        end
      endcase
    end

    // A leading zero may still turn into an octal marker or a hex prefix.
    if (first) begin
      if ((char_q == CH_ZERO) && ((abase_d == BASE_AUTO) || (abase_d == BASE_HEX))) begin
        held_d  = 1'b1;
        phase_d = PH_ZERO;
      end else begin
        if (abase_d == BASE_AUTO) begin
          abase_d = BASE_DEC;
        end
        feed = 1'b1;
      end
    end

    if (msigned_d) begin
      limit = neg_d ? LIM_NEG : LIM_POS;
    end

    if (feed) begin
      phase_d = PH_DIGITS;
      if ((abase_d < BASE_MIN) || (abase_d > BASE_MAX) || (digit_q >= abase_d)) begin
        // The rejected character closes the parse.
        res_req  = 1'b1;
        phase_d  = PH_IDLE;
        counting = 1'b0;
        if (!seen_d) begin
          status_d = ST_NO_DIGITS;
        end else begin
          if (!msigned_d && ovf_d) begin
            value_d = OUT_W'(LIM_UNSIGNED);
          end else begin
            mag = neg_d ? ({VALUE_WIDTH{1'b0}} - acc_d) : acc_d;
            value_d = msigned_d ? OUT_W'($signed(mag)) : OUT_W'(mag);
          end
          status_d = ovf_d ? ST_RANGE : ST_OK;
          offset_d = OFFSET_W'(pos_d);
        end
      end else begin
        seen_d = 1'b1;
        if (!ovf_d) begin
          // acc * base + digit above the limit is the same test as the
          // quotient and remainder cutoff.
          if (sum > SUM_W'(limit)) begin
            ovf_d = 1'b1;
            acc_d = limit;
          end else begin
            acc_d = sum[VALUE_WIDTH-1:0];
          end
        end
      end
    end

    if (counting && (pos_d < POS_W'(MAX_TEXT_LENGTH))) begin
      pos_d = pos_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      abase_q   <= '0;
      seen_q    <= 1'b0;
      ovf_q     <= 1'b0;
      held_q    <= 1'b0;
      pos_q     <= '0;
      msigned_q <= 1'b0;
    end else if (cmd_i.commit) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      abase_q   <= abase_d;
      seen_q    <= seen_d;
      ovf_q     <= ovf_d;
      held_q    <= held_d;
      pos_q     <= pos_d;
      msigned_q <= msigned_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && res_req) begin
      value_q  <= value_d;
      status_q <= status_d;
      offset_q <= offset_d;
    end
  end

  // The held-zero flag only mirrors the prefix phase; it is kept as state.
  assign sts_o.result_req = res_req && (held_q || !held_q);
  assign parsed_value_o   = value_q;
  assign parse_status_o   = status_q;
  assign end_offset_o     = offset_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for integer_text_parser: sends texts one character per beat and checks each parse
// result against a behavioral predictor. Depends on itp_pkg and the integer_text_parser RTL.

module tb_top;
  import itp_pkg::*;

  localparam int unsigned CLK_HALF    = 10;
  // Cycles allowed after the last result before the block counts as idle. A beat that is
  // abandoned or ignored produces nothing we could wait on.
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned NOT_A_DIGIT = 99;
  localparam int unsigned REPORT_MAX  = 10;
  localparam logic [7:0]  CH_NUL      = 8'h00;

  typedef struct packed {
    logic [OUT_W-1:0]    value;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
  } parse_result_t;

  // DUT ports. Every input has a known value from time zero.
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  start_of_text_i = 1'b0;
  logic [7:0]            char_code_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [OUT_W-1:0]      parsed_value_o;
  logic [STATUS_W-1:0]   parse_status_o;
  logic [OFFSET_W-1:0]   end_offset_o;

  // Copies of the configuration registers, as written through the port.
  logic [BASE_W-1:0]      cfg_base   = BASE_DEC;
  logic                   cfg_signed = 1'b1;

  // Parser state as the predictor sees it. Base and signedness are latched at the start of
  // each text, so a register write never affects a text already open.
  parse_phase_e           text_phase    = PH_IDLE;
  logic [VALUE_WIDTH-1:0] text_acc      = '0;
  logic                   text_neg      = 1'b0;
  logic [BASE_W-1:0]      text_radix    = '0;
  logic                   digits_seen   = 1'b0;
  logic                   text_overflow = 1'b0;
  logic [POS_W-1:0]       text_pos      = '0;
  logic                   text_signed   = 1'b0;

  parse_result_t pending_results[$];
  logic [7:0]    text_buf[$];
  int unsigned   mismatch_count   = 0;
  int unsigned   live_beats       = 0;
  int unsigned   cycle_count      = 0;
  int unsigned   long_hold_cycles = 0;
  bit            gaps_on          = 1'b1;

  integer_text_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_of_text_i (start_of_text_i),
    .char_code_i     (char_code_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .parsed_value_o  (parsed_value_o),
    .parse_status_o  (parse_status_o),
    .end_offset_o    (end_offset_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  function automatic bit is_white(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Digit value of a character in any radix up to 36, or NOT_A_DIGIT.
  function automatic int unsigned char_digit(logic [7:0] c);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) return c - CH_ZERO;
    if ((c >= CH_UP_A) && (c <= CH_UP_Z)) return c - CH_UP_A + BASE_DEC;
    if ((c >= CH_LO_A) && (c <= CH_LO_Z)) return c - CH_LO_A + BASE_DEC;
    return NOT_A_DIGIT;
  endfunction

  // Builds the result of a text that has just hit its first rejected character.
  // VALUE_WIDTH equals the port width, so no sign extension is needed.
  function automatic parse_result_t close_text();
    parse_result_t r;
    text_phase = PH_IDLE;
    r.value  = '0;
    r.status = ST_NO_DIGITS;
    r.offset = '0;
    if (digits_seen) begin
      if (!text_signed && text_overflow) begin
        // Unsigned overflow returns the maximum even for a negative text.
        r.value = LIM_UNSIGNED;
      end else begin
        r.value = text_neg ? -text_acc : text_acc;
      end
      r.status = text_overflow ? ST_RANGE : ST_OK;
      r.offset = text_pos[OFFSET_W-1:0];
    end
    return r;
  endfunction

  // Takes one character in the digit phase. Returns 1 when it ends the text.
  function automatic bit take_digit(logic [7:0] c, output parse_result_t r);
    int unsigned            d;
    logic [VALUE_WIDTH-1:0] limit;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] rem;
    d = char_digit(c);
    r = '0;
    text_phase = PH_DIGITS;
    if ((text_radix < BASE_MIN) || (text_radix > BASE_MAX) || (d >= text_radix)) begin
      r = close_text();
      return 1'b1;
    end
    digits_seen = 1'b1;
    // After an overflow the remaining digits are only consumed.
    if (text_overflow) return 1'b0;
    if (text_signed) begin
      limit = text_neg ? LIM_NEG : LIM_POS;
    end else begin
      limit = LIM_UNSIGNED;
    end
    quot = limit / text_radix;
    rem  = limit % text_radix;
    if ((text_acc > quot) || ((text_acc == quot) && (d > rem))) begin
      text_overflow = 1'b1;
      text_acc      = limit;
    end else begin
      text_acc = text_acc * text_radix + d;
    end
    return 1'b0;
  endfunction

  // First character after blanks and sign: a 0 may open a prefix in auto or hex mode.
  function automatic bit begin_number(logic [7:0] c, output parse_result_t r);
    r = '0;
    if ((c == CH_ZERO) && ((text_radix == BASE_AUTO) || (text_radix == BASE_HEX))) begin
      text_phase = PH_ZERO;
      return 1'b0;
    end
    if (text_radix == BASE_AUTO) text_radix = BASE_DEC;
    return take_digit(c, r);
  endfunction

  // Advances the predicted parser by one accepted beat. Returns 1 with the expected result
  // when the beat produces one.
  function automatic bit parse_char(logic sot, logic [7:0] c, output parse_result_t r);
    bit done;
    done = 1'b0;
    r    = '0;
    if (sot) begin
      text_acc      = '0;
      text_neg      = 1'b0;
      digits_seen   = 1'b0;
      text_overflow = 1'b0;
      text_pos      = '0;
      text_signed   = cfg_signed;
      text_radix    = cfg_base;
      if (((cfg_base < BASE_MIN) && (cfg_base != BASE_AUTO)) || (cfg_base > BASE_MAX)) begin
        // An invalid base answers on the first beat; the rest of the text is ignored.
        text_phase = PH_IDLE;
        r.status   = ST_BAD_BASE;
        return 1'b1;
      end
      text_phase = PH_LEAD;
    end
    case (text_phase)
      PH_LEAD: begin
        if (is_white(c)) begin
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          text_neg   = (c == CH_MINUS);
          text_phase = PH_SIGNED;
        end else begin
          done = begin_number(c, r);
        end
      end
      PH_SIGNED: done = begin_number(c, r);
      PH_ZERO: begin
        if ((c == CH_LO_X) || (c == CH_UP_X)) begin
          // The 0 of a prefix is not a digit: "0x" alone yields no digits.
          text_radix = BASE_HEX;
          text_phase = PH_DIGITS;
        end else begin
          if (text_radix == BASE_AUTO) text_radix = BASE_OCT;
          text_acc    = '0;
          digits_seen = 1'b1;
          done        = take_digit(c, r);
        end
      end
      PH_DIGITS: done = take_digit(c, r);
      default: return 1'b0;
    endcase
    if (done) return 1'b1;
    if (text_pos < MAX_TEXT_LENGTH) text_pos++;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Sends one beat and records its expected result. Valid stays high on return so that a
  // following beat can go out back to back; wait_idle lowers it.
  task automatic send_char(logic sot, logic [7:0] c);
    parse_result_t r;
    if (gaps_on && ($urandom_range(0, 3) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    start_of_text_i <= sot;
    char_code_i     <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Beats the parser merely ignores do not count toward the stimulus size.
    if (sot || (text_phase != PH_IDLE)) live_beats++;
    if (parse_char(sot, c, r)) pending_results.push_back(r);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(i == 0, text_buf[i]);
  endtask

  task automatic send_str(string s, bit terminate);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    if (terminate) text_buf.push_back(CH_NUL);
    send_text();
  endtask

  // Stops sending and waits until every expected result is in and the pipeline has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_NUMBER_BASE) begin
      cfg_base = data[BASE_W-1:0];
    end else begin
      cfg_signed = data[0];
    end
  endtask

  // Both registers are rewritten only once the parser is idle. The signed register gets
  // random upper bits, which the block must ignore.
  task automatic set_mode(logic [BASE_W-1:0] base, logic sgn);
    logic [CFG_DATA_W-1:0] d;
    wait_idle();
    write_reg(REG_NUMBER_BASE, base);
    d    = CFG_DATA_W'($urandom);
    d[0] = sgn;
    write_reg(REG_SIGNED_MODE, d);
  endtask

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < BASE_DEC) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - BASE_DEC);
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 2) == 0) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // Magnitudes cluster around the signed and unsigned limits so that both sides of every
  // saturation boundary are reached.
  function automatic logic [VALUE_WIDTH-1:0] pick_magnitude();
    logic [VALUE_WIDTH-1:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: m = VALUE_WIDTH'($urandom_range(0, 99));
      1: m = m >> $urandom_range(1, 63);
      2: m = LIM_POS - 2 + $urandom_range(0, 4);
      3: m = LIM_UNSIGNED - $urandom_range(0, 3);
      default: begin
      end
    endcase
    return m;
  endfunction

  task automatic add_number(logic [VALUE_WIDTH-1:0] mag, int unsigned radix);
    logic [7:0] digits[$];
    do begin
      digits.push_front(digit_char(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    foreach (digits[i]) text_buf.push_back(digits[i]);
  endtask

  // A text of the usual shape with random content: blanks, sign, prefix, digits written in
  // the radix that applies, and a terminator that is sometimes another valid digit.
  task automatic build_text(bit terminate);
    int unsigned radix;
    text_buf.delete();
    repeat ($urandom_range(0, 2)) text_buf.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: text_buf.push_back(CH_PLUS);
      1: text_buf.push_back(CH_MINUS);
      default: begin
      end
    endcase
    radix = ((cfg_base >= BASE_MIN) && (cfg_base <= BASE_MAX)) ? cfg_base : BASE_DEC;
    if ((cfg_base == BASE_AUTO) || (cfg_base == BASE_HEX)) begin
      case ($urandom_range(0, 3))
        0: begin
          text_buf.push_back(CH_ZERO);
          text_buf.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
          radix = BASE_HEX;
        end
        1: begin
          if (cfg_base == BASE_AUTO) begin
            text_buf.push_back(CH_ZERO);
            radix = BASE_OCT;
          end
        end
        default: begin
        end
      endcase
    end
    // Now and then the digits are left out, giving texts such as "+" or "0x" alone.
    if ($urandom_range(0, 15) != 0) begin
      if ($urandom_range(0, 7) == 0) text_buf.push_back(CH_ZERO);
      add_number(pick_magnitude(), radix);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) text_buf.push_back(digit_char($urandom_range(0, radix - 1)));
      end
    end
    if (terminate) begin
      case ($urandom_range(0, 2))
        0: text_buf.push_back(CH_NUL);
        1: text_buf.push_back(blank_char());
        default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset leaves base 10 and signed mode. Bytes sent before any text opens are ignored.
  task automatic test_reset_defaults();
    send_char(1'b0, "7");
    send_char(1'b0, 8'hFF);
    send_str(" -42", 1'b1);
  endtask

  // Automatic base detection, the optional hex prefix, and a prefix with no digits after it.
  task automatic test_base_prefixes();
    set_mode(BASE_AUTO, 1'b1);
    send_str("0x1F", 1'b1);
    send_str("017", 1'b1);
    send_str("0x", 1'b1);
    set_mode(BASE_HEX, 1'b0);
    send_str("0XfF", 1'b1);
  endtask

  // An invalid base answers on the opening beat and swallows the rest of the text.
  task automatic test_invalid_base();
    set_mode(BASE_MIN - 1'b1, 1'b1);
    send_str("56", 1'b0);
    set_mode({BASE_W{1'b1}}, 1'b0);
    send_str("1", 1'b1);
  endtask

  // A new start in the middle of a text drops the old one without a result.
  task automatic test_restart();
    set_mode(BASE_DEC, 1'b1);
    send_str("12", 1'b0);
    send_str("+5", 1'b1);
  endtask

  // Negative unsigned values wrap; overflow saturates in both modes. Thirteen z's in base 36
  // exceed 64 bits.
  task automatic test_out_of_range();
    set_mode(BASE_MAX, 1'b0);
    send_str("-5", 1'b1);
    send_str("-zzzzzzzzzzzzz", 1'b1);
    set_mode(BASE_MAX, 1'b1);
    send_str("zzzzzzzzzzzzz", 1'b1);
  endtask

  // Random texts under a series of settings, the extremes among them. Most texts are well
  // formed; the rest are left open (so the next start abandons them) or random noise.
  task automatic test_random_settings();
    logic [BASE_W-1:0] base;
    int unsigned       target;
    int unsigned       first;
    int unsigned       sel;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: base = BASE_DEC;
        1: base = BASE_AUTO;
        2: base = BASE_HEX;
        3: base = BASE_MIN;
        4: base = BASE_MAX;
        5: base = BASE_OCT;
        6: base = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
        default: begin
          base = $urandom_range(0, 1) ? BASE_MIN - 1'b1
                                      : BASE_W'($urandom_range(BASE_MAX + 1, (1 << BASE_W) - 1));
        end
      endcase
      set_mode(base, p[0]);
      target = (p == 7) ? 30 : 50;
      first  = live_beats;
      while (live_beats - first < target) begin
        sel = $urandom_range(0, 19);
        if (sel < 15) begin
          build_text(1'b1);
          send_text();
        end else if (sel < 17) begin
          build_text(1'b0);
          send_text();
        end else begin
          repeat ($urandom_range(1, 6)) send_char($urandom_range(0, 1), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while short texts keep coming, so results
  // back up inside the block and it has to stall its input.
  task automatic test_output_backpressure();
    set_mode(BASE_DEC, 1'b1);
    long_hold_cycles = 300;
    repeat (25) begin
      text_buf.delete();
      add_number($urandom_range(0, 999), BASE_DEC);
      text_buf.push_back(CH_NUL);
      send_text();
    end
    wait_idle();
  endtask

  // Long texts: the accumulator saturates partway through a run of digits and the rest is
  // still consumed, and a long run of leading zeros leaves the value unchanged.
  task automatic test_long_text();
    set_mode(BASE_DEC, 1'b0);
    text_buf.delete();
    repeat (30) text_buf.push_back(CH_NINE);
    text_buf.push_back(CH_NUL);
    send_text();
    set_mode(BASE_DEC, 1'b1);
    text_buf.delete();
    repeat (24) text_buf.push_back(CH_ZERO);
    text_buf.push_back("5");
    text_buf.push_back(CH_NUL);
    send_text();
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver pacing, result checking and the watchdog
  // ---------------------------------------------------------------------------------------

  initial begin : sink_pacing
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_cycles != 0) begin
        n                = long_hold_cycles;
        long_hold_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (gaps_on && ($urandom_range(0, 5) == 0)) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Each result beat is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    parse_result_t got;
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.value  = parsed_value_o;
      got.status = parse_status_o;
      got.offset = end_offset_o;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result: value %h status %0d offset %0d",
                   got.value, got.status, got.offset);
        end
      end else begin
        want = pending_results.pop_front();
        if ((got.value !== want.value) || (got.status !== want.status) ||
            (got.offset !== want.offset)) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result mismatch: expected value %h status %0d offset %0d", want.value,
                     want.status, want.offset);
            $display("                 got      value %h status %0d offset %0d", got.value,
                     got.status, got.offset);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : main_sequence
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_base_prefixes();
    test_invalid_base();
    test_restart();
    test_out_of_range();
    test_random_settings();
    test_output_backpressure();
    // The last part of the run goes without idling on either side.
    gaps_on = 1'b0;
    test_long_text();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
